// ----- src/oahs_pkg.sv -----
package oahs_pkg;

  // Table geometry. The slot and count fields have fixed widths, so the
  // capacity is a fixed power of two.
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned ROW_W    = KEY_W + 1;

  // Configuration port.
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [CNT_W-1:0] FILL_LIMIT_RESET = CNT_W'(896);

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_FILL_LIMIT = 1'b0
  } reg_idx_e;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  // Status codes of a result word.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

endpackage

// ----- src/oahs_ram.sv -----
module oahs_ram #(
  parameter int unsigned DEPTH = oahs_pkg::CAPACITY,
  parameter int unsigned WIDTH = oahs_pkg::ROW_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write when enabled, otherwise read with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

// ----- src/open_address_hash_set_top.sv -----
// Hash set of 64-bit keys, open addressing with double hashing.
//
// Input channel (in_valid_i / in_stall_o) carries one word: opcode_i and
// key_i. Lookup (0) and insert (1) walk the probe sequence that starts at
// the low key bits and steps by the next key bits forced odd; clear (2)
// empties the table. Each input word yields exactly one result word on the
// output channel (out_valid_o / out_stall_i): status_o, slot_o, count_o.
// The fill_limit register on the APB port (byte address 0) sets the key
// count at which inserts of new keys are refused.
//
// Each probe is one read of the single-port key table followed by a
// compare; the block takes one word at a time.
//
// After reset the table is swept to mark every row empty; the input
// channel stalls meanwhile. The result sits in an output register, so
// a new word is taken while it waits; when the receiver stalls, a
// second finished result waits until the first is taken.
module open_address_hash_set_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [oahs_pkg::KEY_W-1:0]      key_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [oahs_pkg::IDX_W-1:0]      slot_o,
  output logic [oahs_pkg::CNT_W-1:0]      count_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oahs_pkg::PADDR_W-1:0]    paddr,
  input  logic [oahs_pkg::PDATA_W-1:0]    pwdata,
  output logic [oahs_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned IDX_W = oahs_pkg::IDX_W;
  localparam int unsigned KEY_W = oahs_pkg::KEY_W;
  localparam int unsigned CNT_W = oahs_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(oahs_pkg::CAPACITY - 1);

  oahs_pkg::state_e  state_q, state_d;
  oahs_pkg::op_e     op_q, op_d;
  oahs_pkg::status_e res_status_q, res_status_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [IDX_W-1:0]  probes_q, probes_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  fill_q;

  logic                        out_valid_q, out_valid_d;
  logic [2:0]                  out_status_q;
  logic [IDX_W-1:0]            out_slot_q;
  logic [CNT_W-1:0]            out_count_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        rd_valid;
  logic [KEY_W-1:0]            rd_key;
  logic                        hit;
  logic                        empty;
  logic                        last_probe;
  logic                        room;
  logic                        sweep_last;
  logic                        ins_write;
  logic                        cfg_wr;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_addr;
  logic [oahs_pkg::ROW_W-1:0]  ram_wdata;
  logic [oahs_pkg::ROW_W-1:0]  ram_rdata;

  // Key table: each row holds an occupied flag above the key.
  oahs_ram #(
    .DEPTH (oahs_pkg::CAPACITY),
    .WIDTH (oahs_pkg::ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == oahs_pkg::REG_FILL_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= oahs_pkg::FILL_LIMIT_RESET;
    end else if (cfg_wr) begin
      fill_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == oahs_pkg::REG_FILL_LIMIT) begin
      prdata = oahs_pkg::PDATA_W'(fill_q);
    end
  end

  // Handshake and probe decisions.
  assign in_stall_o = (state_q != oahs_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == oahs_pkg::S_DONE) && out_free;

  assign rd_valid   = ram_rdata[KEY_W];
  assign rd_key     = ram_rdata[KEY_W-1:0];
  assign hit        = rd_valid && (rd_key == key_q);
  assign empty      = !rd_valid;
  assign last_probe = (probes_q == LAST_IDX);
  assign room       = (cnt_q < fill_q);
  assign sweep_last = (clr_q == LAST_IDX);
  assign ins_write  = (state_q == oahs_pkg::S_CHECK) && (op_q == oahs_pkg::OP_INSERT) &&
                      empty && room;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oahs_pkg::S_INIT: begin
        if (sweep_last) state_d = oahs_pkg::S_IDLE;
      end
      oahs_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (oahs_pkg::op_e'(opcode_i))
            oahs_pkg::OP_CLEAR:  state_d = oahs_pkg::S_CLR;
            oahs_pkg::OP_RSVD:   state_d = oahs_pkg::S_DONE;
            oahs_pkg::OP_LOOKUP,
            oahs_pkg::OP_INSERT: state_d = oahs_pkg::S_READ;
            default:             state_d = oahs_pkg::S_DONE;
          endcase
        end
      end
      oahs_pkg::S_CLR: begin
        if (sweep_last) state_d = oahs_pkg::S_DONE;
      end
      oahs_pkg::S_READ: begin
        state_d = oahs_pkg::S_CHECK;
      end
      oahs_pkg::S_CHECK: begin
        if (hit || empty || last_probe) begin
          state_d = oahs_pkg::S_DONE;
        end else begin
          state_d = oahs_pkg::S_READ;
        end
      end
      oahs_pkg::S_DONE: begin
        if (out_free) state_d = oahs_pkg::S_IDLE;
      end
      default: state_d = oahs_pkg::S_INIT;
    endcase
  end

  // Datapath and table control.
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    pos_d        = pos_q;
    step_d       = step_q;
    probes_d     = probes_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    ram_we       = 1'b0;
    ram_addr     = pos_q;
    ram_wdata    = {1'b1, key_q};

    unique case (state_q)
      oahs_pkg::S_INIT, oahs_pkg::S_CLR: begin
        // Sweep one row a cycle to mark it empty.
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = {1'b0, key_q};
        clr_d     = clr_q + IDX_W'(1);
        if (sweep_last && (state_q == oahs_pkg::S_CLR)) begin
          cnt_d        = '0;
          res_status_d = oahs_pkg::ST_CLEARED;
          res_slot_d   = '0;
        end
      end
      oahs_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d         = oahs_pkg::op_e'(opcode_i);
          key_d        = key_i;
          pos_d        = key_i[IDX_W-1:0];
          step_d       = {key_i[2*IDX_W-1:IDX_W+1], 1'b1};
          probes_d     = '0;
          clr_d        = '0;
          res_status_d = oahs_pkg::ST_NOT_FOUND;
          res_slot_d   = '0;
        end
      end
      oahs_pkg::S_READ: begin
        // Read address pos_q is presented by default.
      end
      oahs_pkg::S_CHECK: begin
        if (hit) begin
          res_status_d = (op_q == oahs_pkg::OP_INSERT) ? oahs_pkg::ST_PRESENT
                                                       : oahs_pkg::ST_FOUND;
          res_slot_d   = pos_q;
        end else if (empty) begin
          if (op_q != oahs_pkg::OP_INSERT) begin
            res_status_d = oahs_pkg::ST_NOT_FOUND;
          end else if (room) begin
            ram_we       = 1'b1;
            cnt_d        = cnt_q + CNT_W'(1);
            res_status_d = oahs_pkg::ST_INSERTED;
            res_slot_d   = pos_q;
          end else begin
            res_status_d = oahs_pkg::ST_FULL;
          end
        end else if (last_probe) begin
          res_status_d = (op_q == oahs_pkg::OP_INSERT) ? oahs_pkg::ST_FULL
                                                       : oahs_pkg::ST_NOT_FOUND;
        end else begin
          pos_d    = pos_q + step_q;
          probes_d = probes_q + IDX_W'(1);
        end
      end
      oahs_pkg::S_DONE: begin
        // Result waits here until the output register is free.
      end
      default: begin
      end
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oahs_pkg::S_INIT;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers of the word in flight.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    step_q       <= step_d;
    probes_q     <= probes_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
  end

  // Output register.
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_count_q  <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign count_o     = out_count_q;

`ifndef SYNTH
  // The key count never exceeds the table capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(oahs_pkg::CAPACITY))
    else $error("key count above capacity");

  // An insert that writes the table raises the count by exactly one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_write |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not bump key count");

  // A new result word appears only after the sequencer finished a word.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == oahs_pkg::S_DONE))
    else $error("result word without a finished operation");

  // A pending result is never overwritten while the receiver stalls.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("stalled result overwritten");
`endif

endmodule
